// File: rtl/glp_pkg.sv
// Shared types, widths and constants for the Gaussian log density pipeline.
package glp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int GUARD_BITS = 8;
	localparam int LOG_FRAC   = FRAC_BITS + GUARD_BITS;

	// |2y-c-n| and |c-n| widths
	localparam int E_W = DATA_WIDTH + 2;
	localparam int D_W = DATA_WIDTH + 1;

	// ratio keeps 40 bits; anything larger saturates low
	localparam int Q_BITS  = 40;
	localparam int R_SHIFT = 30;
	localparam int BIG_SHIFT = Q_BITS - R_SHIFT;
	localparam int SQ_W    = 2 * Q_BITS - (62 - LOG_FRAC);

	localparam int K_W  = 6;
	localparam int LG_W = K_W + LOG_FRAC;
	localparam int ELL_W = 34;
	localparam int LNT_W = 34;
	localparam int TOT_W = SQ_W + 2;

	// pipeline depths
	localparam int LOG_LAT = 1 + 2 * LOG_FRAC;
	localparam int PAD     = (LOG_LAT + 3) - (Q_BITS + 2);
	localparam int NSTG    = 1 + LOG_LAT + 3 + 1;

	localparam logic [63:0] LN2_Q64     = 64'hB17217F7D1CF79AC;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] observation;
		logic signed [DATA_WIDTH-1:0] clean_estimate;
		logic signed [DATA_WIDTH-1:0] noise_estimate;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] log_density;
		logic                         sigma_invalid;
	} out_word_t;

	// fraction bits of log2 by repeated squaring, elaboration use only
	function automatic logic [LOG_FRAC-1:0] log2_frac_const(input logic [63:0] xin);
		logic [127:0]          p;
		logic [63:0]           x;
		logic [LOG_FRAC-1:0]   f;
		x = xin;
		f = '0;
		for (int i = 0; i < LOG_FRAC; i++) begin
			p = {64'd0, x} * {64'd0, x};
			x = p[125:62];
			f = {f[LOG_FRAC-2:0], x[63]};
			if (x[63]) begin
				x = {1'b0, x[63:1]};
			end
		end
		return f;
	endfunction

	localparam logic [LG_W-1:0] LGPI =
		LG_W'(1 << LOG_FRAC) + LG_W'(log2_frac_const(HALF_PI_Q62));
	localparam logic [LG_W-1:0] LGPI_HALF = LGPI >> 1;

endpackage

// File: rtl/glp_div.sv
// Bit-per-stage restoring divider: ratio = floor(e * 2^30 / d), 40 quotient bits.
module glp_div import glp_pkg::*; (
	input  logic             clk,
	input  logic             adv,
	input  logic [E_W-1:0]   e,
	input  logic [D_W-1:0]   d,
	output logic [Q_BITS-1:0] ratio,
	output logic             big
);

	logic [D_W-1:0]    rem_s  [Q_BITS];
	logic [E_W-1:0]    e_s    [Q_BITS];
	logic [D_W-1:0]    d_s    [Q_BITS];
	logic [Q_BITS-1:0] quot_s [Q_BITS];
	logic              big_s  [Q_BITS];

	for (genvar j = 0; j < Q_BITS; j++) begin : g_st
		localparam int BI = Q_BITS - 1 - j;
		logic [D_W-1:0]    rem_in;
		logic [E_W-1:0]    e_in;
		logic [D_W-1:0]    d_in;
		logic [Q_BITS-1:0] q_in;
		logic              big_in;
		logic              nb;
		logic [D_W:0]      trial;

		if (j == 0) begin : g_first
			// ratio >= 2^40 exactly when e >= d * 2^10
			assign rem_in = D_W'(e >> BIG_SHIFT);
			assign e_in   = e;
			assign d_in   = d;
			assign q_in   = '0;
			assign big_in = ({{BIG_SHIFT - 1{1'b0}}, e} >= {d, {BIG_SHIFT{1'b0}}});
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign e_in   = e_s[j-1];
			assign d_in   = d_s[j-1];
			assign q_in   = quot_s[j-1];
			assign big_in = big_s[j-1];
		end

		// numerator bit from the shifted dividend
		if (BI >= R_SHIFT) begin : g_bit
			assign nb = e_in[BI-R_SHIFT];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign trial = {rem_in, nb};

		always_ff @(posedge clk) begin
			if (adv) begin
				e_s[j]   <= e_in;
				d_s[j]   <= d_in;
				big_s[j] <= big_in;
				if (trial >= {1'b0, d_in}) begin
					rem_s[j]  <= D_W'(trial - {1'b0, d_in});
					quot_s[j] <= {q_in[Q_BITS-2:0], 1'b1};
				end else begin
					rem_s[j]  <= trial[D_W-1:0];
					quot_s[j] <= {q_in[Q_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign ratio = quot_s[Q_BITS-1];
	assign big   = big_s[Q_BITS-1];

endmodule

// File: rtl/glp_log2.sv
// Pipelined log2 of sigma numerator: normalize, then one squaring per two stages.
module glp_log2 import glp_pkg::*; (
	input  logic            clk,
	input  logic            adv,
	input  logic [D_W-1:0]  d,
	output logic [LG_W-1:0] lg
);

	logic [K_W-1:0]      k_s0;
	logic [62:0]         x_s0;
	logic [K_W-1:0]      kc;

	logic [61:0]         hh_s  [LOG_FRAC];
	logic [62:0]         hl_s  [LOG_FRAC];
	logic [63:0]         ll_s  [LOG_FRAC];
	logic [LOG_FRAC-1:0] fa_s  [LOG_FRAC];
	logic [K_W-1:0]      ka_s  [LOG_FRAC];
	logic [62:0]         x_s   [LOG_FRAC];
	logic [LOG_FRAC-1:0] frac_s[LOG_FRAC];
	logic [K_W-1:0]      kb_s  [LOG_FRAC];

	// leading one position
	always_comb begin
		kc = '0;
		for (int i = 0; i < D_W; i++) begin
			if (d[i]) begin
				kc = K_W'(i);
			end
		end
	end

	// mantissa with 62 fraction bits
	always_ff @(posedge clk) begin
		if (adv) begin
			k_s0 <= kc;
			x_s0 <= 63'(d) << (K_W'(62) - kc);
		end
	end

	for (genvar it = 0; it < LOG_FRAC; it++) begin : g_it
		logic [62:0]         x_in;
		logic [LOG_FRAC-1:0] f_in;
		logic [K_W-1:0]      k_in;
		logic [125:0]        sq;
		logic [63:0]         y;

		if (it == 0) begin : g_first
			assign x_in = x_s0;
			assign f_in = '0;
			assign k_in = k_s0;
		end else begin : g_next
			assign x_in = x_s[it-1];
			assign f_in = frac_s[it-1];
			assign k_in = kb_s[it-1];
		end

		// partial products of the square
		always_ff @(posedge clk) begin
			if (adv) begin
				hh_s[it] <= x_in[62:32] * x_in[62:32];
				hl_s[it] <= 63'(x_in[62:32]) * 63'(x_in[31:0]);
				ll_s[it] <= x_in[31:0] * x_in[31:0];
				fa_s[it] <= f_in;
				ka_s[it] <= k_in;
			end
		end

		// sum, keep 62 fraction bits, renormalize
		assign sq = {hh_s[it], 64'd0} + 126'({hl_s[it], 33'd0}) + 126'(ll_s[it]);
		assign y  = sq[125:62];

		always_ff @(posedge clk) begin
			if (adv) begin
				frac_s[it] <= {fa_s[it][LOG_FRAC-2:0], y[63]};
				x_s[it]    <= y[63] ? y[63:1] : y[62:0];
				kb_s[it]   <= ka_s[it];
			end
		end
	end

	assign lg = {kb_s[LOG_FRAC-1], frac_s[LOG_FRAC-1]};

endmodule

// File: rtl/gaussian_log_prob_from_predictions.sv
// Top level: Gaussian log density of an observation from clean and noise estimates.
//
// Input channel sample/sample_valid/sample_stall carries one word per item:
// observation, clean_estimate and noise_estimate, signed Q16.16. Output channel
// result/result_valid/result_stall returns one word per item: log_density in
// Q16.16, saturated at both ends, and sigma_invalid, set with a zero density
// when the clean and noise estimates are equal.
// The block is a 54-stage pipeline that takes one item every cycle, except
// while result_stall holds a waiting result. Depth is set by the
// 49 stages of the log2 unit (a normalize stage, then two per squaring step),
// which run beside the 40-stage divider for the normalized error.
// All stages advance together. When result_stall holds a waiting result,
// the whole pipeline freezes and sample_stall rises in the same cycle; no
// word is dropped or repeated. Reset clears all valid bits, so the pipeline
// comes up empty and ready.
module gaussian_log_prob_from_predictions import glp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  in_word_t  sample,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	logic adv;
	logic vld_q [NSTG];
	logic inv_q [NSTG-1];

	// stage 1
	logic signed [E_W-1:0] ediff;
	logic signed [D_W-1:0] ddiff;
	logic [E_W-1:0]        e_s1;
	logic [D_W-1:0]        d_s1;

	// divider and square
	logic [Q_BITS-1:0] ratio;
	logic              big;
	logic [15:0]       paa_s;
	logic [39:0]       pab_s;
	logic [63:0]       pbb_s;
	logic              big_sa_s;
	logic [79:0]       sqsum;
	logic [SQ_W-1:0]   q_sq_s;
	logic              big_sq_s;
	logic [SQ_W-1:0]   padq_q [PAD];
	logic              padb_q [PAD];

	// log term
	logic [LG_W-1:0]         lg;
	logic signed [ELL_W-1:0] ell;
	logic [31:0]             mag_s;
	logic                    neg_s;
	logic [63:0]             ph_s;
	logic [63:0]             pl_s;
	logic                    neg_l1_s;
	logic [64:0]             lnsum;
	logic [LNT_W-1:0]        lnterm_s;

	// final
	logic signed [TOT_W-1:0] total;
	out_word_t               out_s;

	// whole pipeline moves unless a finished word is held
	assign adv          = !(vld_q[NSTG-1] && result_stall);
	assign sample_stall = !adv;
	assign result_valid = vld_q[NSTG-1];
	assign result       = out_s;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= sample_valid;
			for (int i = 1; i < NSTG; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// error and spread magnitudes
	assign ediff = E_W'(sample.observation) + E_W'(sample.observation)
		- E_W'(sample.clean_estimate) - E_W'(sample.noise_estimate);
	assign ddiff = D_W'(sample.clean_estimate) - D_W'(sample.noise_estimate);

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1     <= ediff[E_W-1] ? E_W'(-ediff) : ediff;
			d_s1     <= ddiff[D_W-1] ? D_W'(-ddiff) : ddiff;
			inv_q[0] <= (sample.clean_estimate == sample.noise_estimate);
			for (int i = 1; i < NSTG - 1; i++) begin
				inv_q[i] <= inv_q[i-1];
			end
		end
	end

	glp_div u_div (
		.clk   (clk),
		.adv   (adv),
		.e     (e_s1),
		.d     (d_s1),
		.ratio (ratio),
		.big   (big)
	);

	glp_log2 u_log2 (
		.clk (clk),
		.adv (adv),
		.d   (d_s1),
		.lg  (lg)
	);

	// ratio squared in pieces: 8-bit top, 32-bit bottom
	assign sqsum = {paa_s, 64'd0} + 80'({pab_s, 33'd0}) + 80'(pbb_s);

	always_ff @(posedge clk) begin
		if (adv) begin
			paa_s    <= ratio[39:32] * ratio[39:32];
			pab_s    <= 40'(ratio[39:32]) * 40'(ratio[31:0]);
			pbb_s    <= ratio[31:0] * ratio[31:0];
			big_sa_s <= big;
			q_sq_s   <= sqsum[79:79-SQ_W+1];
			big_sq_s <= big_sa_s;
			padq_q[0] <= q_sq_s;
			padb_q[0] <= big_sq_s;
			for (int i = 1; i < PAD; i++) begin
				padq_q[i] <= padq_q[i-1];
				padb_q[i] <= padb_q[i-1];
			end
		end
	end

	// ln term: ln2 * (FRAC_BITS - log2 d - log2(pi)/2)
	assign ell = ELL_W'(FRAC_BITS) * ELL_W'(1 << LOG_FRAC) - ELL_W'(lg) - ELL_W'(LGPI_HALF);
	assign lnsum = 65'(ph_s) + 65'(pl_s >> 32);

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s    <= ell[ELL_W-1];
			mag_s    <= ell[ELL_W-1] ? 32'(-ell) : 32'(ell);
			ph_s     <= 64'(mag_s) * 64'(LN2_Q64[63:32]);
			pl_s     <= 64'(mag_s) * 64'(LN2_Q64[31:0]);
			neg_l1_s <= neg_s;
			lnterm_s <= neg_l1_s ? LNT_W'(-{1'b0, lnsum[64:32]}) : LNT_W'({1'b0, lnsum[64:32]});
		end
	end

	// combine, drop guard bits, saturate
	assign total = {{(TOT_W - LNT_W){lnterm_s[LNT_W-1]}}, lnterm_s} - {2'b00, padq_q[PAD-1]};

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s.sigma_invalid <= inv_q[NSTG-2];
			if (inv_q[NSTG-2]) begin
				out_s.log_density <= '0;
			end else if (padb_q[PAD-1]) begin
				out_s.log_density <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
			end else if (total[TOT_W-1:GUARD_BITS+DATA_WIDTH-1] == '0
				|| total[TOT_W-1:GUARD_BITS+DATA_WIDTH-1] == '1) begin
				out_s.log_density <= total[GUARD_BITS+DATA_WIDTH-1:GUARD_BITS];
			end else if (total[TOT_W-1]) begin
				out_s.log_density <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
			end else begin
				out_s.log_density <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
			end
		end
	end

	// sigma zero always comes out with a zero density
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.sigma_invalid) |-> (result.log_density == '0))
		else $error("sigma_invalid word with nonzero density");

	// a taken word occupies the first stage next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> vld_q[0])
		else $error("accepted word lost at pipeline entry");

	// a held output freezes the entry stage too
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(vld_q[0]))
		else $error("pipeline moved while output held");

endmodule

// File: test/gaussian_log_prob_from_predictions_test.sv
// Self-checking testbench for the Gaussian log density pipeline.
module gaussian_log_prob_from_predictions_test;
	import glp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		in_word_t word;
		int       gap;
		bit       drain;
	} pending_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      sample_valid = 1'b0;
	logic      sample_stall;
	in_word_t  sample = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;

	pending_t  pending_samples[$];
	out_word_t expected_densities[$];
	int        gap_left = 0;
	int        stall_left = 0;
	int        error_count = 0;
	int        idle_cycles = 0;
	longint    cycle_count = 0;

	gaussian_log_prob_from_predictions dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #5 clk = ~clk;

	// log2 of a normalized mantissa with LOG_FRAC fraction bits
	function automatic logic signed [63:0] log2_q(input logic [63:0] mant, input int expo);
		logic [127:0] prod;
		logic [63:0]  x;
		logic [63:0]  frac;
		x = mant;
		frac = '0;
		for (int i = 0; i < LOG_FRAC; i++) begin
			prod = {64'd0, x} * {64'd0, x};
			x = prod[125:62];
			frac = {frac[62:0], x[63]};
			if (x[63]) begin
				x = x >> 1;
			end
		end
		return (64'(expo) <<< LOG_FRAC) + $signed(frac);
	endfunction

	// expected density word for one sample word
	function automatic out_word_t density_model(input in_word_t s);
		logic signed [127:0] y, c, n, e, d, r, q, lnterm, tot, res;
		logic signed [127:0] max_v, min_v;
		logic [127:0]        prod;
		logic [63:0]         x, mag, lnmag;
		logic signed [63:0]  lg, lgpi, ell;
		int                  k;
		out_word_t           o;
		y = s.observation;
		c = s.clean_estimate;
		n = s.noise_estimate;
		max_v = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
		min_v = -(128'sd1 <<< (DATA_WIDTH - 1));
		e = 2 * y - c - n;
		if (e < 0) e = -e;
		d = c - n;
		if (d < 0) d = -d;
		o.sigma_invalid = 1'b0;
		if (d == 0) begin
			o.log_density = '0;
			o.sigma_invalid = 1'b1;
			return o;
		end
		r = (e <<< 30) / d;
		// ratio too large: far below range
		if (r[127:63] != '0) begin
			o.log_density = min_v[DATA_WIDTH-1:0];
			return o;
		end
		q = (r * r) >>> (62 - LOG_FRAC);
		k = 0;
		for (int i = 0; i < 64; i++) begin
			if (d[i]) k = i;
		end
		x = (k <= 62) ? (d[63:0] << (62 - k)) : (d[63:0] >> 1);
		lg = log2_q(x, k);
		lgpi = log2_q(HALF_PI_Q62, 1);
		ell = (64'(FRAC_BITS) <<< LOG_FRAC) - lg - (lgpi >>> 1);
		mag = (ell < 0) ? -ell : ell;
		prod = {64'd0, mag} * {64'd0, LN2_Q64};
		lnmag = prod[127:64];
		lnterm = $signed({64'd0, lnmag});
		if (ell < 0) lnterm = -lnterm;
		tot = lnterm - q;
		res = tot >>> (LOG_FRAC - FRAC_BITS);
		if (res > max_v) res = max_v;
		else if (res < min_v) res = min_v;
		o.log_density = res[DATA_WIDTH-1:0];
		return o;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 7) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	task automatic add_sample(input logic [31:0] y, input logic [31:0] c,
			input logic [31:0] n, input int gap, input bit drain);
		pending_t p;
		p.word.observation = y;
		p.word.clean_estimate = c;
		p.word.noise_estimate = n;
		p.gap = gap;
		p.drain = drain;
		pending_samples.push_back(p);
	endtask

	// sender: one word per handshake, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		logic     next_valid;
		in_word_t next_word;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			gap_left = 0;
		end else begin
			cycle_count++;
			next_valid = sample_valid;
			next_word = sample;
			if (sample_valid && !sample_stall) begin
				expected_densities.push_back(density_model(sample));
				next_valid = 1'b0;
			end
			if (!(sample_valid && sample_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() > 0 &&
						!(pending_samples[0].drain && expected_densities.size() != 0)) begin
					next_valid = 1'b1;
					next_word = pending_samples[0].word;
					pending_samples.pop_front();
					gap_left = (pending_samples.size() > 0) ? pending_samples[0].gap : 0;
				end
			end
			sample_valid <= next_valid;
			sample <= next_word;
		end
	end

	// receiver: check each word against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		logic      next_stall;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_densities.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_densities.pop_front();
					if (result.sigma_invalid !== want.sigma_invalid)
						report_mismatch($sformatf("sigma_invalid got %b want %b",
							result.sigma_invalid, want.sigma_invalid));
					if (result.log_density !== want.log_density)
						report_mismatch($sformatf("log_density got %h want %h",
							result.log_density, want.log_density));
				end
			end
			// quiet window with no stalls
			if (cycle_count > 2000 && cycle_count < 2600) begin
				next_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else begin
				stall_left = pick_gap();
				next_stall = (stall_left > 0);
				if (stall_left > 0) stall_left--;
			end
			result_stall <= next_stall;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL gaussian_log_prob_from_predictions");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] y, c, n, span;
		int          mode;
		// directed: extremes, zero sigma, huge ratio, tiny sigma
		add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
		add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
		add_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0);
		add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0);
		add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
		add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
		add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
		add_sample(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000, 0, 0);
		add_sample(32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 0, 0);
		add_sample(32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
		add_sample(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 0, 0);
		add_sample(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 0, 0);
		add_sample(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 0, 0);
		add_sample(32'h0001_0000, 32'h0001_8000, 32'h0000_8000, 0, 0);
		add_sample(32'h0005_0000, 32'h0001_0000, 32'h0000_0000, 0, 0);
		add_sample(32'hFFFF_0000, 32'h0000_0000, 32'h0001_6A0A, 0, 0);
		add_sample(32'h1234_5678, 32'h1234_5678, 32'h1234_5679, 0, 0);
		add_sample(32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 0, 0);
		add_sample(32'h0100_0000, 32'h0000_0000, 32'h0000_0002, 0, 0);
		add_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0);
		// random: mostly near the mean with sane sigma, some raw noise
		for (int i = 0; i < 700; i++) begin
			mode = $urandom_range(0, 9);
			c = $urandom();
			n = $urandom();
			y = $urandom();
			if (mode < 5) begin
				span = $urandom() >> $urandom_range(0, 31);
				n = c + span;
				y = (c >>> 1) + (n >>> 1) + ($urandom() >> $urandom_range(4, 31))
					- ($urandom() >> $urandom_range(4, 31));
			end else if (mode == 5) begin
				n = c;
			end else if (mode == 6) begin
				n = c ^ (32'd1 << $urandom_range(0, 31));
			end
			add_sample(y, c, n, (i >= 250 && i < 350) ? 0 : pick_gap(), i == 400);
		end
		#1 arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_samples.size() == 0);
		@(posedge clk);
		while (sample_valid) @(posedge clk);
		while (expected_densities.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_densities.size() == 0) begin
			$display("PASS gaussian_log_prob_from_predictions");
		end else begin
			$display("FAIL gaussian_log_prob_from_predictions");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/glp_pkg.sv
rtl/glp_div.sv
rtl/glp_log2.sv
rtl/gaussian_log_prob_from_predictions.sv
test/gaussian_log_prob_from_predictions_test.sv
